@@ src/atlcd_pkg.sv @@
// Shared types, codes and reply tables of the AT line command decoder.
`default_nettype none
package atlcd_pkg;

	// Jobs passed from the front end to the back end.
	localparam logic [1:0] OP_OK  = 2'd0;
	localparam logic [1:0] OP_CMD = 2'd1;
	localparam logic [1:0] OP_ERR = 2'd2;

	// Kinds of result on the output stream.
	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_CHAR  = 2'd2;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam int         PREFIX_LEN   = 6;
	localparam int         COUNT_W      = 7;
	localparam int         LINE_W       = 4;

	typedef struct packed {
		logic [1:0]        op;
		logic [LINE_W-1:0] line;
	} cmd_t;

	function automatic logic [7:0] ok_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = 8'h4F; // O
			2'd1:    c = 8'h4B; // K
			2'd2:    c = 8'h0D;
			default: c = 8'h0A;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] err_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h45; // E
			3'd1:    c = 8'h52; // R
			3'd2:    c = 8'h52; // R
			3'd3:    c = 8'h3A; // :
			3'd4:    c = 8'h2D; // -
			3'd5:    c = 8'h31; // 1
			3'd6:    c = 8'h0D;
			default: c = 8'h0A;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ src/atlcd_front.sv @@
// Front end: collects line bytes and turns each finished line into a job.
`default_nettype none
module atlcd_front #(
	parameter int LINE_CAPACITY = 100,
	parameter int TEXT_END      = 20,
	parameter int LINE_COUNT    = 6
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     in_valid,
	input  wire  [7:0]                              in_byte,
	output logic                                    in_ready,
	input  wire                                     q_full,
	output logic                                    q_push,
	output atlcd_pkg::cmd_t                         q_cmd,
	output logic [(TEXT_END-atlcd_pkg::PREFIX_LEN)*8-1:0] q_text
);
	localparam int TEXT_N = TEXT_END - atlcd_pkg::PREFIX_LEN;

	logic [7:0]                      store_q [TEXT_END];
	logic [atlcd_pkg::COUNT_W-1:0]   count_q;
	logic                            take;
	logic                            is_nl;
	logic                            is_full;
	logic                            match;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign is_nl    = (in_byte == atlcd_pkg::NEWLINE_BYTE);
	assign is_full  = (count_q >= atlcd_pkg::COUNT_W'(LINE_CAPACITY));

	assign match = (store_q[0] == 8'h41) && (store_q[1] == 8'h54) &&
		(store_q[2] == 8'h2B) && (store_q[3] == 8'h4C) && (store_q[5] == 8'h3D) &&
		(store_q[4] >= 8'h31) && (store_q[4] <= 8'(48 + LINE_COUNT));

	always_comb begin
		q_push      = take && (is_nl || is_full);
		q_cmd.line  = atlcd_pkg::LINE_W'(store_q[4] - 8'h31);
		if (!is_nl) begin
			q_cmd.op = atlcd_pkg::OP_ERR;
		end else if (match) begin
			q_cmd.op = atlcd_pkg::OP_CMD;
		end else begin
			q_cmd.op = atlcd_pkg::OP_OK;
		end
		for (int k = 0; k < TEXT_N; k++) begin
			q_text[k*8 +: 8] = store_q[atlcd_pkg::PREFIX_LEN + k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < TEXT_END; i++) begin
				store_q[i] <= '0;
			end
		end else if (take) begin
			if (is_nl || is_full) begin
				count_q <= '0;
				for (int i = 0; i < TEXT_END; i++) begin
					store_q[i] <= '0;
				end
			end else begin
				count_q <= count_q + 1'b1;
				for (int i = 0; i < TEXT_END; i++) begin
					if (count_q == atlcd_pkg::COUNT_W'(i)) begin
						store_q[i] <= in_byte;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ src/atlcd_queue.sv @@
// Two-entry job queue between the front end and the back end.
`default_nettype none
module atlcd_queue #(
	parameter int WIDTH = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire [WIDTH-1:0]  push_data,
	output logic             full,
	input  wire              pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/atlcd_back.sv @@
// Back end: feeds a job's results to the output register one per cycle unless stalled.
`default_nettype none
module atlcd_back #(
	parameter int TEXT_END = 20
) (
	input  wire                                           clk,
	input  wire                                           arst_n,
	input  wire                                           q_valid,
	input  atlcd_pkg::cmd_t                               q_cmd,
	input  wire  [(TEXT_END-atlcd_pkg::PREFIX_LEN)*8-1:0] q_text,
	output logic                                          q_pop,
	output logic                                          out_valid,
	input  wire                                           out_ready,
	output logic [1:0]                                    out_kind,
	output logic [7:0]                                    out_value,
	output logic                                          out_last
);
	localparam int TEXT_N = TEXT_END - atlcd_pkg::PREFIX_LEN;
	localparam int TXT_W  = $clog2(TEXT_N + 1);
	localparam int IDX_W  = (TXT_W > 3) ? TXT_W : 3;
	localparam int TIX_W  = (TEXT_N > 1) ? $clog2(TEXT_N) : 1;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_CLEAR   = 3'd1;
	localparam logic [2:0] ST_TEXT    = 3'd2;
	localparam logic [2:0] ST_OK_MID  = 3'd3;
	localparam logic [2:0] ST_OK_LAST = 3'd4;
	localparam logic [2:0] ST_ERR     = 3'd5;

	logic [2:0]                        state_q;
	logic [2:0]                        state_d;
	logic [IDX_W-1:0]                  idx_q;
	logic [IDX_W-1:0]                  idx_d;
	logic [atlcd_pkg::LINE_W-1:0]      line_q;
	logic [TEXT_N*8-1:0]               text_q;
	logic                              out_free;
	logic                              emit;
	logic [1:0]                        kind_d;
	logic [7:0]                        value_d;
	logic                              last_d;
	logic [7:0]                        text_byte;
	logic                              text_done;

	assign out_free  = !out_valid || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign text_byte = text_q[idx_q[TIX_W-1:0]*8 +: 8];
	assign text_done = (idx_q == IDX_W'(TEXT_N)) || (text_byte == 8'h00);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		emit    = 1'b0;
		kind_d  = atlcd_pkg::KIND_REPLY;
		value_d = atlcd_pkg::ok_char(idx_q[1:0]);
		last_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idx_d = '0;
				if (q_valid) begin
					unique case (q_cmd.op)
						atlcd_pkg::OP_CMD: state_d = ST_CLEAR;
						atlcd_pkg::OP_ERR: state_d = ST_ERR;
						default:           state_d = ST_OK_LAST;
					endcase
				end
			end
			ST_CLEAR: begin
				emit    = 1'b1;
				kind_d  = atlcd_pkg::KIND_CLEAR;
				value_d = 8'(line_q);
				state_d = ST_TEXT;
				idx_d   = '0;
			end
			ST_TEXT: begin
				if (text_done) begin
					state_d = ST_OK_MID;
					idx_d   = '0;
				end else begin
					emit    = 1'b1;
					kind_d  = atlcd_pkg::KIND_CHAR;
					value_d = text_byte;
					idx_d   = idx_q + 1'b1;
				end
			end
			ST_OK_MID: begin
				emit = 1'b1;
				if (idx_q[1:0] == 2'd3) begin
					state_d = ST_OK_LAST;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_OK_LAST: begin
				emit   = 1'b1;
				last_d = (idx_q[1:0] == 2'd3);
				idx_d  = idx_q + 1'b1;
				if (last_d) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				emit    = 1'b1;
				value_d = atlcd_pkg::err_char(idx_q[2:0]);
				last_d  = (idx_q[2:0] == 3'd7);
				idx_d   = idx_q + 1'b1;
				if (last_d) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			line_q <= q_cmd.line;
			text_q <= q_text;
		end
		if (out_free && emit) begin
			out_kind  <= kind_d;
			out_value <= value_d;
			out_last  <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_IDLE || out_free) begin
				state_q <= state_d;
				idx_q   <= idx_d;
			end
			if (out_free) begin
				out_valid <= (state_q != ST_IDLE) && emit;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/at_line_command_to_lcd_text.sv @@
// Top level of the AT line command decoder that drives a text display.
//
// Input stream (s_tvalid, s_tready, s_tdata): one received serial byte per
// transaction. Output stream (m_tvalid, m_tready, m_tdata, m_tuser, m_tlast):
// one result per transaction. m_tuser gives its kind (serial reply byte, clear
// of a display line, display character), m_tdata the byte or line number, and
// m_tlast marks the final result caused by one input byte.
// Ordinary bytes are taken and produce nothing. A newline or an overlong line
// becomes a job in a two-entry queue; the back end then emits its results one
// per cycle while the receiver takes them: 4 for a plain line, 8 for the error
// reply, and up to 23 for a display command (clear, text, two OK replies), plus
// a step without a result to fetch the job and another at the end of the text.
// The first result passes through the queue, the back end's state register and
// the output register. The back end fetches a new job only once it has finished
// the last one; meanwhile the queue holds up to two jobs.
// Reset empties the line store, the queue and the output register.
// When the receiver stalls, the output register holds its result, the back end
// waits, and once the queue is full s_tready drops until a job leaves it.
`default_nettype none
module at_line_command_to_lcd_text #(
	parameter int LINE_CAPACITY = 100,
	parameter int TEXT_END      = 20,
	parameter int LINE_COUNT    = 6
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // [7:0] value
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);
	localparam int TEXT_N = TEXT_END - atlcd_pkg::PREFIX_LEN;
	localparam int CMD_W  = $bits(atlcd_pkg::cmd_t);
	localparam int JOB_W  = CMD_W + TEXT_N * 8;

	logic                q_full;
	logic                q_push;
	logic                q_pop;
	logic                q_valid;
	atlcd_pkg::cmd_t     push_cmd;
	atlcd_pkg::cmd_t     pop_cmd;
	logic [TEXT_N*8-1:0] push_text;
	logic [TEXT_N*8-1:0] pop_text;
	logic [JOB_W-1:0]    pop_job;

	// Front end: keeps the line store and the byte count.
	atlcd_front #(
		.LINE_CAPACITY(LINE_CAPACITY),
		.TEXT_END     (TEXT_END),
		.LINE_COUNT   (LINE_COUNT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_byte (s_tdata),
		.in_ready(s_tready),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (push_cmd),
		.q_text  (push_text)
	);

	// The job carries a copy of the text positions so the store may refill at once.
	atlcd_queue #(
		.WIDTH(JOB_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({push_text, push_cmd}),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.pop_data (pop_job)
	);

	assign pop_cmd  = pop_job[CMD_W-1:0];
	assign pop_text = pop_job[JOB_W-1:CMD_W];

	// Back end: result sequencer with its output register.
	atlcd_back #(
		.TEXT_END(TEXT_END)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (pop_cmd),
		.q_text   (pop_text),
		.q_pop    (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_kind (m_tuser),
		.out_value(m_tdata),
		.out_last (m_tlast)
	);

endmodule
`default_nettype wire
